### rtl/bpa_pkg.sv
// Buddy page allocator package: sizes, status codes, controller states, result struct.
// Used by bpa_ctrl and buddy_page_allocator; no dependencies.
package bpa_pkg;

    localparam int TOP_ORDER   = 9;
    localparam int NUM_ORDERS  = TOP_ORDER + 1;
    localparam int ORDER_BITS  = 4;
    localparam int PAGE_BITS   = 20;
    localparam int STACK_DEPTH = 1024;
    localparam int IDX_BITS    = $clog2(STACK_DEPTH);
    localparam int COUNT_BITS  = IDX_BITS + 1;
    localparam int ADDR_BITS   = ORDER_BITS + IDX_BITS;
    localparam int RAM_DEPTH   = NUM_ORDERS * STACK_DEPTH;
    localparam int STATUS_BITS = 3;
    localparam int IN_BITS     = 24;
    localparam int OUT_BITS    = 24;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK       = 3'd0,
        ST_NOMEM    = 3'd1,
        ST_BADORDER = 3'd2,
        ST_MISALIGN = 3'd3,
        ST_NULLFULL = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_POP,
        S_LOAD,
        S_SPLIT,
        S_DONE
    } state_t;

    typedef enum logic {
        ACT_ALLOC = 1'b0,
        ACT_FREE  = 1'b1
    } action_t;

    typedef struct packed {
        status_t               status;
        logic [PAGE_BITS-1:0]  page;
    } result_t;

endpackage

### rtl/buddy_page_allocator.sv
// Buddy page allocator top level: stream ports, output register, sequencer.
// Depends on bpa_pkg and bpa_ctrl.
// Free: check and push; allocate: check, order scan, pop, load, split pushes.
// One item in flight; the next is taken once the previous result is in the output register.
// Stack RAM: one port, one access per cycle, sets the split and pop cost.
// Reset: asynchronous, active low; clears all stack counts, output empty; no clearing pass.
module buddy_page_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bpa_pkg::IN_BITS-1:0]   s_tdata,   // order[3:0], block_page[23:4]
    input  logic                          s_tuser,   // action
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bpa_pkg::OUT_BITS-1:0]  m_tdata    // status[2:0], granted_page[22:3], zero
);

    logic              m_valid_reg;
    bpa_pkg::result_t  m_res_reg;
    logic              res_valid;
    logic              res_ready;
    bpa_pkg::result_t  res;

    bpa_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (s_tvalid),
        .req_ready  (s_tready),
        .req_action (s_tuser),
        .req_order  (s_tdata[bpa_pkg::ORDER_BITS-1:0]),
        .req_page   (s_tdata[bpa_pkg::ORDER_BITS +: bpa_pkg::PAGE_BITS]),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    assign res_ready = !m_valid_reg || m_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {{(bpa_pkg::OUT_BITS - $bits(bpa_pkg::result_t)){1'b0}},
                        m_res_reg.page, m_res_reg.status};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (res_ready)
            m_valid_reg <= res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
            m_res_reg <= res;
    end

endmodule

### rtl/bpa_stack_ram.sv
// Single-port synchronous RAM holding the free stacks, registered read data.
// Generic; no package dependency.
module bpa_stack_ram #(
    parameter int DEPTH     = 10240,
    parameter int WIDTH     = 20,
    parameter int ADDR_BITS = 14
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] addr,
    input  logic [WIDTH-1:0]     wdata,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
                mem[addr] <= wdata;
            else
                rdata <= mem[addr];
        end
    end

endmodule

### rtl/bpa_ctrl.sv
// Allocator sequencer: per-order stack counts, order scan, pop, split pushes, free checks.
// Depends on bpa_pkg and bpa_stack_ram.
module bpa_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  logic                             req_action,
    input  logic [bpa_pkg::ORDER_BITS-1:0]   req_order,
    input  logic [bpa_pkg::PAGE_BITS-1:0]    req_page,
    output logic                             res_valid,
    input  logic                             res_ready,
    output bpa_pkg::result_t                 res
);

    bpa_pkg::state_t state_reg, state_next;

    logic                             action_reg;
    logic [bpa_pkg::ORDER_BITS-1:0]   order_reg;
    logic [bpa_pkg::PAGE_BITS-1:0]    page_reg;
    logic [bpa_pkg::ORDER_BITS-1:0]   src_reg, src_next;
    logic [bpa_pkg::ORDER_BITS-1:0]   j_reg, j_next;
    logic [bpa_pkg::PAGE_BITS-1:0]    base_reg, base_next;
    bpa_pkg::result_t                 res_reg, res_next;
    logic [bpa_pkg::COUNT_BITS-1:0]   cnt_reg [bpa_pkg::NUM_ORDERS];

    logic [bpa_pkg::ORDER_BITS-1:0]   cnt_idx;
    logic [bpa_pkg::COUNT_BITS-1:0]   cur_cnt;
    logic                             cnt_we;
    logic [bpa_pkg::COUNT_BITS-1:0]   cnt_wval;
    logic [bpa_pkg::ORDER_BITS-1:0]   j_dec;
    logic [bpa_pkg::PAGE_BITS-1:0]    align_mask;
    logic [bpa_pkg::PAGE_BITS-1:0]    split_page;
    logic                             cnt_full;

    logic                             ram_en;
    logic                             ram_we;
    logic [bpa_pkg::ADDR_BITS-1:0]    ram_addr;
    logic [bpa_pkg::PAGE_BITS-1:0]    ram_wdata;
    logic [bpa_pkg::PAGE_BITS-1:0]    ram_rdata;

    bpa_stack_ram #(
        .DEPTH     (bpa_pkg::RAM_DEPTH),
        .WIDTH     (bpa_pkg::PAGE_BITS),
        .ADDR_BITS (bpa_pkg::ADDR_BITS)
    ) u_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign req_ready = (state_reg == bpa_pkg::S_IDLE);
    assign res_valid = (state_reg == bpa_pkg::S_DONE);
    assign res       = res_reg;

    assign j_dec      = j_reg - bpa_pkg::ORDER_BITS'(1);
    assign align_mask = ~({bpa_pkg::PAGE_BITS{1'b1}} << order_reg);
    assign split_page = base_reg + (bpa_pkg::PAGE_BITS'(1) << j_dec);

    // single count read port
    always_comb
    begin
        unique case (state_reg)
            bpa_pkg::S_CHECK: cnt_idx = order_reg;
            bpa_pkg::S_SPLIT: cnt_idx = j_dec;
            default:          cnt_idx = src_reg;
        endcase
    end

    assign cur_cnt  = (cnt_idx <= bpa_pkg::ORDER_BITS'(bpa_pkg::TOP_ORDER)) ?
                      cnt_reg[cnt_idx] : '0;
    assign cnt_full = (cur_cnt >= bpa_pkg::COUNT_BITS'(bpa_pkg::STACK_DEPTH));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bpa_pkg::S_IDLE:
            begin
                if (req_valid)
                    state_next = bpa_pkg::S_CHECK;
            end
            bpa_pkg::S_CHECK:
            begin
                if (action_reg == bpa_pkg::ACT_FREE ||
                    order_reg > bpa_pkg::ORDER_BITS'(bpa_pkg::TOP_ORDER))
                    state_next = bpa_pkg::S_DONE;
                else
                    state_next = bpa_pkg::S_SCAN;
            end
            bpa_pkg::S_SCAN:
            begin
                priority if (cur_cnt != '0)
                    state_next = bpa_pkg::S_POP;
                else if (src_reg == bpa_pkg::ORDER_BITS'(bpa_pkg::TOP_ORDER))
                    state_next = bpa_pkg::S_DONE;
                else
                    state_next = bpa_pkg::S_SCAN;
            end
            bpa_pkg::S_POP:   state_next = bpa_pkg::S_LOAD;
            bpa_pkg::S_LOAD:  state_next = bpa_pkg::S_SPLIT;
            bpa_pkg::S_SPLIT:
            begin
                if (j_reg == order_reg)
                    state_next = bpa_pkg::S_DONE;
            end
            bpa_pkg::S_DONE:
            begin
                if (res_ready)
                    state_next = bpa_pkg::S_IDLE;
            end
            default:          state_next = bpa_pkg::S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        src_next  = src_reg;
        j_next    = j_reg;
        base_next = base_reg;
        res_next  = res_reg;
        cnt_we    = 1'b0;
        cnt_wval  = cur_cnt;
        ram_en    = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = {cnt_idx, cur_cnt[bpa_pkg::IDX_BITS-1:0]};
        ram_wdata = page_reg;
        unique case (state_reg)
            bpa_pkg::S_CHECK:
            begin
                src_next     = order_reg;
                res_next.page = '0;
                if (action_reg == bpa_pkg::ACT_FREE)
                begin
                    priority if (page_reg == '0)
                        res_next.status = bpa_pkg::ST_NULLFULL;
                    else if (order_reg > bpa_pkg::ORDER_BITS'(bpa_pkg::TOP_ORDER))
                        res_next.status = bpa_pkg::ST_BADORDER;
                    else if ((page_reg & align_mask) != '0)
                        res_next.status = bpa_pkg::ST_MISALIGN;
                    else if (cnt_full)
                        res_next.status = bpa_pkg::ST_NULLFULL;
                    else
                    begin
                        res_next.status = bpa_pkg::ST_OK;
                        ram_en   = 1'b1;
                        ram_we   = 1'b1;
                        cnt_we   = 1'b1;
                        cnt_wval = cur_cnt + bpa_pkg::COUNT_BITS'(1);
                    end
                end
                else
                begin
                    res_next.status = bpa_pkg::ST_BADORDER;
                end
            end
            bpa_pkg::S_SCAN:
            begin
                priority if (cur_cnt != '0)
                    res_next.status = bpa_pkg::ST_OK;
                else if (src_reg == bpa_pkg::ORDER_BITS'(bpa_pkg::TOP_ORDER))
                    res_next.status = bpa_pkg::ST_NOMEM;
                else
                    src_next = src_reg + bpa_pkg::ORDER_BITS'(1);
            end
            bpa_pkg::S_POP:
            begin
                cnt_we   = 1'b1;
                cnt_wval = cur_cnt - bpa_pkg::COUNT_BITS'(1);
                ram_en   = 1'b1;
                ram_addr = {cnt_idx, cnt_wval[bpa_pkg::IDX_BITS-1:0]};
            end
            bpa_pkg::S_LOAD:
            begin
                base_next = ram_rdata;
                j_next    = src_reg;
            end
            bpa_pkg::S_SPLIT:
            begin
                // stacks from the requested order up to the popped order were empty: a push always fits
                if (j_reg == order_reg)
                    res_next.page = base_reg;
                else
                begin
                    ram_en    = 1'b1;
                    ram_we    = 1'b1;
                    ram_wdata = split_page;
                    cnt_we    = 1'b1;
                    cnt_wval  = cur_cnt + bpa_pkg::COUNT_BITS'(1);
                    j_next    = j_dec;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bpa_pkg::S_IDLE;
            for (int i = 0; i < bpa_pkg::NUM_ORDERS; i++)
                cnt_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cnt_we && cnt_idx <= bpa_pkg::ORDER_BITS'(bpa_pkg::TOP_ORDER))
                cnt_reg[cnt_idx] <= cnt_wval;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            action_reg <= req_action;
            order_reg  <= req_order;
            page_reg   <= req_page;
        end
        src_reg  <= src_next;
        j_reg    <= j_next;
        base_reg <= base_next;
        res_reg  <= res_next;
    end

    a_split_above_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bpa_pkg::S_SPLIT |-> j_reg >= order_reg)
        else $error("split index below requested order");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bpa_pkg::S_SCAN |->
            src_reg <= bpa_pkg::ORDER_BITS'(bpa_pkg::TOP_ORDER))
        else $error("scan ran past top order");

    a_pop_then_load: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bpa_pkg::S_POP |=> state_reg == bpa_pkg::S_LOAD)
        else $error("pop not followed by load");

    a_write_only_with_count: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ram_en && cnt_we && cnt_wval == cur_cnt + bpa_pkg::COUNT_BITS'(1))
        else $error("stack write without count increment");

endmodule

### tb/sv/tb_buddy_page_allocator.sv
// Self-checking testbench for buddy_page_allocator: queue-fed stream driver, result monitor,
// and a behavioral allocator model predicting status and granted page. Depends on bpa_pkg.
`timescale 1ns / 100ps

module tb_buddy_page_allocator;

    typedef struct {
        bpa_pkg::action_t                   act;
        logic [bpa_pkg::ORDER_BITS-1:0]     ord;
        logic [bpa_pkg::PAGE_BITS-1:0]      pg;
    } request_t;

    logic                          clk      = 1'b0;
    logic                          rst_n    = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [bpa_pkg::IN_BITS-1:0]   s_tdata  = '0;
    logic                          s_tuser  = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [bpa_pkg::OUT_BITS-1:0]  m_tdata;

    request_t           pending_reqs[$];
    request_t           next_req;
    bpa_pkg::result_t   expected_results[$];
    bpa_pkg::result_t   want;

    // allocator model state
    logic [bpa_pkg::PAGE_BITS-1:0] stack_pages [bpa_pkg::NUM_ORDERS][bpa_pkg::STACK_DEPTH];
    int                            free_depth [bpa_pkg::NUM_ORDERS];

    int  err_cnt = 0;
    int  n_in    = 0;
    int  n_out   = 0;
    int  status_hits [5];
    bit  quiet;

    buddy_page_allocator u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic bpa_pkg::result_t serve_request(bpa_pkg::action_t act,
                                                       logic [bpa_pkg::ORDER_BITS-1:0] ord,
                                                       logic [bpa_pkg::PAGE_BITS-1:0] pg);
        bpa_pkg::result_t              r;
        int                            src;
        bit                            room;
        logic [bpa_pkg::PAGE_BITS-1:0] base;
        r.status = bpa_pkg::ST_OK;
        r.page   = '0;
        if (act == bpa_pkg::ACT_ALLOC)
        begin
            if (ord > bpa_pkg::TOP_ORDER)
                r.status = bpa_pkg::ST_BADORDER;
            else
            begin
                src = ord;
                while (src <= bpa_pkg::TOP_ORDER && free_depth[src] == 0)
                    src++;
                if (src > bpa_pkg::TOP_ORDER)
                    r.status = bpa_pkg::ST_NOMEM;
                else
                begin
                    room = 1'b1;
                    for (int j = ord; j < src; j++)
                        if (free_depth[j] >= bpa_pkg::STACK_DEPTH)
                            room = 1'b0;
                    if (!room)
                        r.status = bpa_pkg::ST_NULLFULL;
                    else
                    begin
                        free_depth[src]--;
                        base = stack_pages[src][free_depth[src]];
                        // upper halves, largest first
                        for (int j = src; j > ord; j--)
                        begin
                            stack_pages[j-1][free_depth[j-1]] = base + (20'd1 << (j - 1));
                            free_depth[j-1]++;
                        end
                        r.page = base;
                    end
                end
            end
        end
        else
        begin
            if (pg == '0)
                r.status = bpa_pkg::ST_NULLFULL;
            else if (ord > bpa_pkg::TOP_ORDER)
                r.status = bpa_pkg::ST_BADORDER;
            else if ((pg & ((20'd1 << ord) - 20'd1)) != '0)
                r.status = bpa_pkg::ST_MISALIGN;
            else if (free_depth[ord] >= bpa_pkg::STACK_DEPTH)
                r.status = bpa_pkg::ST_NULLFULL;
            else
            begin
                stack_pages[ord][free_depth[ord]] = pg;
                free_depth[ord]++;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int exp_val);
        $display("ERROR result %0d: %s got 0x%0h, expected 0x%0h", n_out, what, got, exp_val);
        err_cnt++;
    endtask

    task automatic add_request(bpa_pkg::action_t act, logic [bpa_pkg::ORDER_BITS-1:0] ord,
                               logic [bpa_pkg::PAGE_BITS-1:0] pg);
        request_t q;
        q.act = act;
        q.ord = ord;
        q.pg  = pg;
        pending_reqs.push_back(q);
    endtask

    task automatic add_random_request();
        int                             pick;
        logic [bpa_pkg::ORDER_BITS-1:0] ord;
        logic [bpa_pkg::PAGE_BITS-1:0]  pg;
        pick = $urandom_range(0, 99);
        ord  = bpa_pkg::ORDER_BITS'($urandom_range(0, bpa_pkg::TOP_ORDER));
        pg   = bpa_pkg::PAGE_BITS'($urandom);
        if (pick < 45)
            add_request(bpa_pkg::ACT_ALLOC, ord, pg);
        else if (pick < 85)
        begin
            pg = pg & ~((20'd1 << ord) - 20'd1);
            if (pg == '0)
                pg = 20'd1 << ord;
            add_request(bpa_pkg::ACT_FREE, ord, pg);
        end
        else if (pick < 90)
            add_request($urandom_range(0, 1) ? bpa_pkg::ACT_FREE : bpa_pkg::ACT_ALLOC,
                        bpa_pkg::ORDER_BITS'($urandom_range(bpa_pkg::TOP_ORDER + 1, 15)), pg);
        else if (pick < 95)
            add_request(bpa_pkg::ACT_FREE,
                        bpa_pkg::ORDER_BITS'($urandom_range(1, bpa_pkg::TOP_ORDER)), pg | 20'd1);
        else
            add_request(bpa_pkg::ACT_FREE, bpa_pkg::ORDER_BITS'($urandom_range(0, 15)), '0);
    endtask

    assign quiet = (n_in >= 200 && n_in < 400);

    // request driver
    always @(posedge clk)
    begin
        if (rst_n && (!s_tvalid || s_tready))
        begin
            if (pending_reqs.size() > 0 && (quiet || $urandom_range(0, 99) >= 20))
            begin
                next_req  = pending_reqs.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {next_req.pg, next_req.ord};
                s_tuser  <= next_req.act;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
            m_tready <= quiet || ($urandom_range(0, 99) >= 20);
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected transfer, data", m_tdata, 0);
                else
                begin
                    want = expected_results.pop_front();
                    if (m_tdata[2:0] != want.status)
                        report_mismatch("status", m_tdata[2:0], want.status);
                    if (m_tdata[22:3] != want.page)
                        report_mismatch("granted_page", m_tdata[22:3], want.page);
                end
                n_out++;
            end
            if (s_tvalid && s_tready)
            begin
                want = serve_request(bpa_pkg::action_t'(s_tuser), s_tdata[3:0], s_tdata[23:4]);
                status_hits[want.status]++;
                expected_results.push_back(want);
                n_in++;
            end
        end
    end

    initial
    begin
        for (int o = 0; o < bpa_pkg::NUM_ORDERS; o++)
            free_depth[o] = 0;
        for (int k = 0; k < 5; k++)
            status_hits[k] = 0;

        // directed
        add_request(bpa_pkg::ACT_ALLOC, 4'd0,  20'h00000);
        add_request(bpa_pkg::ACT_ALLOC, 4'd15, 20'hFFFFF);
        add_request(bpa_pkg::ACT_FREE,  4'd0,  20'h00000);
        add_request(bpa_pkg::ACT_FREE,  4'd15, 20'h00000);
        add_request(bpa_pkg::ACT_FREE,  4'd12, 20'h00001);
        add_request(bpa_pkg::ACT_FREE,  4'd10, 20'h80000);
        add_request(bpa_pkg::ACT_ALLOC, 4'd11, 20'h00000);
        add_request(bpa_pkg::ACT_FREE,  4'd1,  20'hFFFFF);
        add_request(bpa_pkg::ACT_FREE,  4'd9,  20'h00300);
        add_request(bpa_pkg::ACT_FREE,  4'd9,  20'hFFE00);
        add_request(bpa_pkg::ACT_FREE,  4'd9,  20'h00200);
        add_request(bpa_pkg::ACT_ALLOC, 4'd0,  20'h00000);
        add_request(bpa_pkg::ACT_ALLOC, 4'd9,  20'h00000);
        add_request(bpa_pkg::ACT_ALLOC, 4'd9,  20'h00000);
        add_request(bpa_pkg::ACT_FREE,  4'd0,  20'hFFFFF);
        add_request(bpa_pkg::ACT_ALLOC, 4'd0,  20'hABCDE);
        for (int o = 1; o < bpa_pkg::TOP_ORDER; o++)
            add_request(bpa_pkg::ACT_ALLOC, bpa_pkg::ORDER_BITS'(o), 20'h55555);
        add_request(bpa_pkg::ACT_ALLOC, 4'd13, 20'h00000);
        add_request(bpa_pkg::ACT_FREE,  4'd14, 20'h04000);

        // random
        for (int i = 0; i < 924; i++)
            add_random_request();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() > 0 || s_tvalid)
            @(posedge clk);
        while (expected_results.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Ran %0d requests, %0d results: ok %0d, no memory %0d, bad order %0d,",
                 n_in, n_out, status_hits[bpa_pkg::ST_OK], status_hits[bpa_pkg::ST_NOMEM],
                 status_hits[bpa_pkg::ST_BADORDER]);
        $display("misaligned %0d, null page or full stack %0d",
                 status_hits[bpa_pkg::ST_MISALIGN], status_hits[bpa_pkg::ST_NULLFULL]);
        if (err_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Timeout: %0d results still outstanding", expected_results.size());
        $display("Mismatches found");
        $finish;
    end

endmodule

### files.f
rtl/bpa_pkg.sv
rtl/bpa_stack_ram.sv
rtl/bpa_ctrl.sv
rtl/buddy_page_allocator.sv
tb/sv/tb_buddy_page_allocator.sv
